@@ design/tbdc_pkg.sv @@
// Shared types and constants for the two-beam direction counter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tbdc_pkg;

  localparam int unsigned CountW   = 16;
  localparam int unsigned MsW      = 16;
  localparam int unsigned TickW    = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 24;

  // Opcode of an input item
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_BEAM = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_TICKS_PER_MS    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIN_CROSSING_MS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_CROSSING_MS = 2'd2;

  // Reset values
  localparam logic [TickW-1:0]  TICKS_PER_MS_RST = 8'd20;
  localparam logic [MsW-1:0]    MIN_MS_RST       = 16'd50;
  localparam logic [MsW-1:0]    MAX_MS_RST       = 16'd1000;
  localparam logic [CountW-1:0] PEOPLE_RST       = 16'd3;
  localparam logic [CountW-1:0] PEOPLE_MAX       = 16'hFFFF;
  localparam logic [MsW-1:0]    MS_MAX           = 16'hFFFF;

  typedef struct packed {
    logic [TickW-1:0] ticks_per_ms;
    logic [MsW-1:0]   min_crossing_ms;
    logic [MsW-1:0]   max_crossing_ms;
  } cfg_t;

  typedef struct packed {
    logic              opcode;
    logic              beam_one_level;
    logic              beam_two_level;
  } item_t;

  typedef struct packed {
    logic [CountW-1:0] people_count;
    logic              count_changed;
  } res_t;

endpackage

@@ design/tbdc_cfg_regs.sv @@
// Configuration register file of the two-beam direction counter.
// Depends on tbdc_pkg for the register indexes and the cfg_t bundle.
`timescale 1ns / 1ps

module tbdc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [tbdc_pkg::CfgIdxW-1:0]  wr_index,
  input  logic [tbdc_pkg::CfgDataW-1:0] wr_data,
  output tbdc_pkg::cfg_t                cfg
);
  import tbdc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write; unknown indexes leave everything as it is
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_TICKS_PER_MS:    cfg_nxt.ticks_per_ms    = wr_data[TickW-1:0];
        CFG_MIN_CROSSING_MS: cfg_nxt.min_crossing_ms = wr_data[MsW-1:0];
        CFG_MAX_CROSSING_MS: cfg_nxt.max_crossing_ms = wr_data[MsW-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_per_ms    <= TICKS_PER_MS_RST;
      cfg_r.min_crossing_ms <= MIN_MS_RST;
      cfg_r.max_crossing_ms <= MAX_MS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ design/tbdc_core.sv @@
// Counter state and the per-item update: prescaler, crossing window, flags.
// Depends on tbdc_pkg; the result is combinational and registered by the top.
`timescale 1ns / 1ps

module tbdc_core (
  input  logic           clk,
  input  logic           rst_n,
  input  tbdc_pkg::cfg_t cfg,
  input  logic           step,
  input  tbdc_pkg::item_t item,
  output tbdc_pkg::res_t res
);
  import tbdc_pkg::*;

  logic [CountW-1:0] people_inside_r, people_inside_nxt;
  logic              beam_one_seen_r, beam_one_seen_nxt;
  logic              beam_two_seen_r, beam_two_seen_nxt;
  logic [MsW-1:0]    elapsed_ms_r, elapsed_ms_nxt;
  logic [TickW-1:0]  ticks_left_r, ticks_left_nxt;
  logic              changed;

  logic win_late;
  logic win_in;
  logic partner_one;
  logic partner_two;

  // Window compare against the elapsed time since the last beam event
  assign win_late    = elapsed_ms_r > cfg.max_crossing_ms;
  assign win_in      = !win_late && (elapsed_ms_r >= cfg.min_crossing_ms);
  assign partner_one = beam_one_seen_r && !win_late;
  assign partner_two = beam_two_seen_r && !win_late;

  // Next state for one item
  always_comb begin
    people_inside_nxt = people_inside_r;
    beam_one_seen_nxt = beam_one_seen_r;
    beam_two_seen_nxt = beam_two_seen_r;
    elapsed_ms_nxt    = elapsed_ms_r;
    ticks_left_nxt    = ticks_left_r;
    changed           = 1'b0;
    if (item.opcode == OP_TICK) begin
      if (ticks_left_r <= TickW'(1)) begin
        if (elapsed_ms_r != MS_MAX) elapsed_ms_nxt = elapsed_ms_r + MsW'(1);
        ticks_left_nxt = cfg.ticks_per_ms;
      end else begin
        ticks_left_nxt = ticks_left_r - TickW'(1);
      end
    end else if (item.beam_two_level) begin
      // Beam two: one then two counts an entry
      beam_one_seen_nxt = 1'b0;
      beam_two_seen_nxt = !partner_one;
      if (partner_one && win_in && people_inside_r != PEOPLE_MAX) begin
        people_inside_nxt = people_inside_r + CountW'(1);
        changed           = 1'b1;
      end
      elapsed_ms_nxt = '0;
      ticks_left_nxt = cfg.ticks_per_ms;
    end else if (item.beam_one_level) begin
      // Beam one: two then one counts an exit
      beam_two_seen_nxt = 1'b0;
      beam_one_seen_nxt = !partner_two;
      if (partner_two && win_in && people_inside_r != '0) begin
        people_inside_nxt = people_inside_r - CountW'(1);
        changed           = 1'b1;
      end
      elapsed_ms_nxt = '0;
      ticks_left_nxt = cfg.ticks_per_ms;
    end
  end

  // Advance state on each item taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      people_inside_r <= PEOPLE_RST;
      beam_one_seen_r <= 1'b0;
      beam_two_seen_r <= 1'b0;
      elapsed_ms_r    <= '0;
      ticks_left_r    <= TICKS_PER_MS_RST;
    end else if (step) begin
      people_inside_r <= people_inside_nxt;
      beam_one_seen_r <= beam_one_seen_nxt;
      beam_two_seen_r <= beam_two_seen_nxt;
      elapsed_ms_r    <= elapsed_ms_nxt;
      ticks_left_r    <= ticks_left_nxt;
    end
  end

  assign res.people_count  = people_inside_nxt;
  assign res.count_changed = changed;

  // Both side flags are never pending together
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(beam_one_seen_r && beam_two_seen_r))
    else $error("both beam flags set");

  // Count moves only when the item reports a change
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    step && !changed |=> $stable(people_inside_r))
    else $error("count moved without change flag");

  a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
    step && changed |=> people_inside_r != $past(people_inside_r))
    else $error("change flag without count update");

  // A tick never touches the side flags
  a_tick_flags: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.opcode == OP_TICK |=> $stable(beam_one_seen_r) && $stable(beam_two_seen_r))
    else $error("tick altered beam flags");

endmodule

@@ design/two_beam_direction_counter_unit.sv @@
// Top level of the two-beam direction counter: stream ports, input and result registers.
// Depends on tbdc_pkg, tbdc_cfg_regs and tbdc_core.
`timescale 1ns / 1ps

// Takes one item per clock cycle while the output register is empty or its result
// is taken: an item is captured in the input register, is evaluated by the core's
// compare and increment logic, and its result lands in the output register.
// Both registers move together whenever the output register is empty
// or its result is taken, so a stalled result holds back at most one item.
// Configuration writes are always accepted and should be made while idle.
module two_beam_direction_counter_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: [0] opcode, [1] beam_one_level, [2] beam_two_level, [7:3] zero
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [tbdc_pkg::InDataW-1:0]  in_tdata,
  // out_tdata: [15:0] people_count, [16] count_changed, [23:17] zero
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [tbdc_pkg::OutDataW-1:0] out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tbdc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [tbdc_pkg::CfgDataW-1:0] cfg_data
);
  import tbdc_pkg::*;

  cfg_t  cfg;
  item_t item_r;
  logic  in_valid_r;
  res_t  res;
  res_t  out_res_r;
  logic  out_valid_r;
  logic  advance;
  logic  step;

  assign cfg_ready = 1'b1;

  tbdc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Pipeline moves when the result register is free or being drained
  assign advance   = !out_valid_r || out_tready;
  assign step      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.opcode         <= in_tdata[0];
      item_r.beam_one_level <= in_tdata[1];
      item_r.beam_two_level <= in_tdata[2];
    end
  end

  tbdc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .step  (step),
    .item  (item_r),
    .res   (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.count_changed, out_res_r.people_count};

endmodule
